// ===== src/wavhp_pkg.sv =====
package wavhp_pkg;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NOT_RIFF = 3'd1;
    localparam logic [2:0] ERR_NOT_WAVE = 3'd2;
    localparam logic [2:0] ERR_NO_FMT   = 3'd3;
    localparam logic [2:0] ERR_FMT_SHORT = 3'd4;
    localparam logic [2:0] ERR_NOT_PCM  = 3'd5;
    localparam logic [2:0] ERR_NOT_16BIT = 3'd6;
    localparam logic [2:0] ERR_NO_DATA  = 3'd7;

    // Tags as they assemble little-endian from the byte stream
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
    localparam logic [31:0] FORMAT_PCM   = 32'd1;
    localparam logic [31:0] BITS_NEEDED  = 32'd16;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         error_code;
        logic [15:0]        channels;
        logic [31:0]        rate_hz;
        logic signed [15:0] sample;
        logic               last_sample;
    } t_result;

endpackage

// ===== src/wav_header_parser_unit.sv =====
// WAV header parser. Takes one file byte per transfer and checks the RIFF/WAVE
// header (PCM, 16 bits per sample), skipping extra fmt bytes and unknown chunks,
// then gives one header result, one signed sample per two data bytes (the final
// one marked), or one error code. A byte is accepted every cycle as long as the
// result register is empty or being drained; each result is registered and
// appears in the cycle after the byte that causes it. After the final result or
// an error, further bytes are accepted and dropped until reset.
module wav_header_parser_unit
    import wavhp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_result  o_out_data
);

    localparam logic [3:0] PH_RIFF      = 4'd0;
    localparam logic [3:0] PH_RSIZE     = 4'd1;
    localparam logic [3:0] PH_WAVE      = 4'd2;
    localparam logic [3:0] PH_FMTID     = 4'd3;
    localparam logic [3:0] PH_FMTSIZE   = 4'd4;
    localparam logic [3:0] PH_FORMAT    = 4'd5;
    localparam logic [3:0] PH_CHANS     = 4'd6;
    localparam logic [3:0] PH_RATE      = 4'd7;
    localparam logic [3:0] PH_BYTERATE  = 4'd8;
    localparam logic [3:0] PH_ALIGN     = 4'd9;
    localparam logic [3:0] PH_BITS      = 4'd10;
    localparam logic [3:0] PH_CHUNKID   = 4'd11;
    localparam logic [3:0] PH_CHUNKSIZE = 4'd12;
    localparam logic [3:0] PH_SKIP      = 4'd13;
    localparam logic [3:0] PH_DATASIZE  = 4'd14;
    localparam logic [3:0] PH_DATA      = 4'd15;

    logic [3:0]  r_phase,       n_phase;
    logic [1:0]  r_bif,         n_bif;
    logic [31:0] r_field_shift, n_field_shift;
    logic [31:0] r_bytes_left,  n_bytes_left;
    logic [15:0] r_chan,        n_chan;
    logic [31:0] r_rate,        n_rate;
    logic [7:0]  r_low_byte,    n_low_byte;
    logic        r_done,        n_done;
    logic        r_out_valid;
    t_result     r_out_data;

    logic        in_fire;
    logic [7:0]  b;
    logic        eof;
    logic [31:0] acc;
    logic        len2;
    logic        fld_done;
    logic [31:0] bl_dec;
    logic        em;
    logic [1:0]  em_kind;
    logic [2:0]  em_err;
    logic [15:0] em_smp;
    logic        em_last;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign b   = i_in_data.file_byte;
    assign eof = i_in_data.end_of_file;

    assign acc    = r_field_shift | ({24'd0, b} << {r_bif, 3'b000});
    assign len2   = (r_phase == PH_FORMAT) || (r_phase == PH_CHANS) ||
                    (r_phase == PH_ALIGN) || (r_phase == PH_BITS);
    assign fld_done = len2 ? (r_bif != 2'd0) : (r_bif == 2'd3);
    assign bl_dec = (r_bytes_left != 32'd0) ? (r_bytes_left - 32'd1) : r_bytes_left;

    always_comb begin
        n_phase       = r_phase;
        n_bif         = r_bif;
        n_field_shift = r_field_shift;
        n_bytes_left  = r_bytes_left;
        n_chan        = r_chan;
        n_rate        = r_rate;
        n_low_byte    = r_low_byte;
        n_done        = r_done;
        em            = 1'b0;
        em_kind       = KIND_HEADER;
        em_err        = ERR_NONE;
        em_smp        = 16'd0;
        em_last       = 1'b0;

        if (!r_done) begin
            // field assembly for every phase that reads a header field
            if (r_phase != PH_SKIP && r_phase != PH_DATA) begin
                if (fld_done) begin
                    n_field_shift = 32'd0;
                    n_bif         = 2'd0;
                end else begin
                    n_field_shift = acc;
                    n_bif         = r_bif + 2'd1;
                end
            end

            case (r_phase)
                PH_RIFF: begin
                    if (fld_done) begin
                        if (acc != TAG_RIFF) begin
                            em = 1'b1; em_kind = KIND_ERROR; em_err = ERR_NOT_RIFF;
                            n_done = 1'b1;
                        end else begin
                            n_phase = PH_RSIZE;
                        end
                    end
                end
                PH_RSIZE: begin
                    if (fld_done) n_phase = PH_WAVE;
                end
                PH_WAVE: begin
                    if (fld_done) begin
                        if (acc != TAG_WAVE) begin
                            em = 1'b1; em_kind = KIND_ERROR; em_err = ERR_NOT_WAVE;
                            n_done = 1'b1;
                        end else begin
                            n_phase = PH_FMTID;
                        end
                    end
                end
                PH_FMTID: begin
                    if (fld_done) begin
                        if (acc != TAG_FMT) begin
                            em = 1'b1; em_kind = KIND_ERROR; em_err = ERR_NO_FMT;
                            n_done = 1'b1;
                        end else begin
                            n_phase = PH_FMTSIZE;
                        end
                    end
                end
                PH_FMTSIZE: begin
                    if (fld_done) begin
                        if (acc < FMT_MIN_SIZE) begin
                            em = 1'b1; em_kind = KIND_ERROR; em_err = ERR_FMT_SHORT;
                            n_done = 1'b1;
                        end else begin
                            n_bytes_left = acc - FMT_MIN_SIZE;
                            n_phase      = PH_FORMAT;
                        end
                    end
                end
                PH_FORMAT: begin
                    if (fld_done) begin
                        if (acc != FORMAT_PCM) begin
                            em = 1'b1; em_kind = KIND_ERROR; em_err = ERR_NOT_PCM;
                            n_done = 1'b1;
                        end else begin
                            n_phase = PH_CHANS;
                        end
                    end
                end
                PH_CHANS: begin
                    if (fld_done) begin
                        n_chan  = acc[15:0];
                        n_phase = PH_RATE;
                    end
                end
                PH_RATE: begin
                    if (fld_done) begin
                        n_rate  = acc;
                        n_phase = PH_BYTERATE;
                    end
                end
                PH_BYTERATE: begin
                    if (fld_done) n_phase = PH_ALIGN;
                end
                PH_ALIGN: begin
                    if (fld_done) n_phase = PH_BITS;
                end
                PH_BITS: begin
                    if (fld_done) begin
                        if (acc != BITS_NEEDED) begin
                            em = 1'b1; em_kind = KIND_ERROR; em_err = ERR_NOT_16BIT;
                            n_done = 1'b1;
                        end else begin
                            n_phase = (r_bytes_left != 32'd0) ? PH_SKIP : PH_CHUNKID;
                        end
                    end
                end
                PH_CHUNKID: begin
                    if (fld_done) n_phase = (acc == TAG_DATA) ? PH_DATASIZE : PH_CHUNKSIZE;
                end
                PH_CHUNKSIZE: begin
                    if (fld_done) begin
                        n_bytes_left = acc;
                        n_phase      = (acc != 32'd0) ? PH_SKIP : PH_CHUNKID;
                    end
                end
                PH_SKIP: begin
                    n_bytes_left = bl_dec;
                    if (bl_dec == 32'd0) n_phase = PH_CHUNKID;
                end
                PH_DATASIZE: begin
                    if (fld_done) begin
                        n_bytes_left = acc;
                        em = 1'b1; em_kind = KIND_HEADER;
                        if (acc < 32'd2) n_done = 1'b1;
                        else             n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_bytes_left = bl_dec;
                    if (r_bif == 2'd0) begin
                        n_low_byte = b;
                        n_bif      = 2'd1;
                        if (bl_dec == 32'd0) n_done = 1'b1;
                    end else begin
                        n_bif   = 2'd0;
                        em      = 1'b1;
                        em_kind = KIND_SAMPLE;
                        em_smp  = {b, r_low_byte};
                        em_last = (bl_dec < 32'd2) || eof;
                        if (em_last) n_done = 1'b1;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            // early end of file: stop; flag missing data if not in data phase
            if (eof && !n_done) begin
                n_done = 1'b1;
                if (!em && n_phase != PH_DATA) begin
                    em = 1'b1; em_kind = KIND_ERROR; em_err = ERR_NO_DATA;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_RIFF;
            r_bif         <= 2'd0;
            r_field_shift <= 32'd0;
            r_bytes_left  <= 32'd0;
            r_chan        <= 16'd0;
            r_rate        <= 32'd0;
            r_low_byte    <= 8'd0;
            r_done        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase       <= n_phase;
                r_bif         <= n_bif;
                r_field_shift <= n_field_shift;
                r_bytes_left  <= n_bytes_left;
                r_chan        <= n_chan;
                r_rate        <= n_rate;
                r_low_byte    <= n_low_byte;
                r_done        <= n_done;
            end
            // hold the result until its transfer, load a new one on accept
            if (in_fire) begin
                r_out_valid <= em;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && em) begin
            r_out_data.kind        <= em_kind;
            r_out_data.error_code  <= em_err;
            r_out_data.channels    <= n_chan;
            r_out_data.rate_hz     <= n_rate;
            r_out_data.sample      <= em_smp;
            r_out_data.last_sample <= em_last;
        end
    end

endmodule
